/* design/krt_pkg.sv */
// Shared types and constants for the keyed report table.
package krt_pkg;

	localparam int unsigned DEPTH_DEF = 32;
	localparam int unsigned READ_CAP  = 32;
	localparam logic [31:0] TTL_RESET = 32'd86400;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [63:0]        call_hi;
		logic [55:0]        call_lo;
		logic [31:0]        time_stamp;
		logic [31:0]        freq_hz;
		logic signed [7:0]  snr_db;
		logic [47:0]        grid;
		logic               has_position;
		logic [31:0]        lat_bits;
		logic [31:0]        lon_bits;
	} entry_t;

endpackage

/* design/krt_ram.sv */
// Entry memory: one write port, one read port with registered read data.
module krt_ram #(
	parameter int unsigned DEPTH = krt_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  krt_pkg::entry_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output krt_pkg::entry_t          rdata
);
	import krt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/keyed_report_table_ttl.sv */
// Top level: command sequencer for the keyed report table with TTL expiry.
// Clear empties the table without leaving IDLE. Add and read first walk the entries
// and drop those older than the TTL; add then walks them again for the key or the
// oldest entry and writes unless the new stamp is older; read emits its results,
// each read from memory first. busy is high for a whole add or read, not a clear.
// Reset empties the table and loads the TTL with one day; the receiver cannot stall.
module keyed_report_table_ttl #(
	parameter int unsigned TABLE_DEPTH = krt_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ttl_we,
	input  logic [31:0]        ttl_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [63:0]        call_hi,
	input  logic [55:0]        call_lo,
	input  logic [31:0]        time_stamp,
	input  logic [31:0]        freq_hz,
	input  logic signed [7:0]  snr_db,
	input  logic [47:0]        grid_text,
	input  logic               has_position,
	input  logic [31:0]        lat_bits,
	input  logic [31:0]        lon_bits,
	input  logic [5:0]         max_entries,
	output logic               strobe,
	output logic [63:0]        out_call_hi,
	output logic [55:0]        out_call_lo,
	output logic [31:0]        out_time,
	output logic [31:0]        out_freq_hz,
	output logic signed [7:0]  out_snr_db,
	output logic [47:0]        out_grid,
	output logic               out_has_position,
	output logic [31:0]        out_lat_bits,
	output logic [31:0]        out_lon_bits,
	output logic               entry_valid,
	output logic               last_item
);
	import krt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		IDLE, EX_RD, EX_EV, SR_RD, SR_EV, WR, RD_RD, RD_EM
	} state_t;

	state_t        st_q;
	logic [31:0]   ttl_q;
	logic [1:0]    cmd_q;
	entry_t        ent_q;
	logic [5:0]    maxn_q;
	logic [CW-1:0] cnt_q, i_q, keep_q;
	logic [6:0]    n_q;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q, min_idx_q;
	logic [31:0]   hit_time_q, min_time_q;
	entry_t        out_q;
	logic          strobe_q, valid_q, last_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic [32:0]   age;
	logic          keep_ok;
	logic [6:0]    n_next;

	krt_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// signed age: stamps later than now are kept
	assign age     = {1'b0, ent_q.time_stamp} - {1'b0, rdata.time_stamp};
	assign keep_ok = age[32] || (age[31:0] <= ttl_q);

	always_comb begin
		n_next = {1'b0, maxn_q};
		if (7'(keep_q) < n_next) begin
			n_next = 7'(keep_q);
		end
		if (n_next > 7'(READ_CAP)) begin
			n_next = 7'(READ_CAP);
		end
	end

	always_comb begin
		raddr = i_q[AW-1:0];
		we    = 1'b0;
		waddr = keep_q[AW-1:0];
		wdata = rdata;
		case (st_q)
			EX_EV: begin
				we = keep_ok;
			end
			WR: begin
				wdata = ent_q;
				if (hit_q) begin
					we    = ent_q.time_stamp >= hit_time_q;
					waddr = hit_idx_q;
				end else if (cnt_q < CW'(TABLE_DEPTH)) begin
					we    = 1'b1;
					waddr = cnt_q[AW-1:0];
				end else begin
					we    = ent_q.time_stamp >= min_time_q;
					waddr = min_idx_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= IDLE;
			ttl_q    <= TTL_RESET;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			valid_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (ttl_we) begin
				ttl_q <= ttl_wdata;
			end
			case (st_q)
				IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						maxn_q <= max_entries;
						ent_q  <= '{call_hi, call_lo, time_stamp, freq_hz, snr_db,
							grid_text, has_position, lat_bits, lon_bits};
						i_q    <= '0;
						keep_q <= '0;
						if (cmd == CMD_ADD || cmd == CMD_READ) begin
							st_q <= EX_RD;
						end else if (cmd == CMD_CLEAR) begin
							cnt_q <= '0;
						end
					end
				end
				EX_RD: begin
					if (i_q == cnt_q) begin
						cnt_q <= keep_q;
						i_q   <= '0;
						hit_q <= 1'b0;
						n_q   <= n_next;
						if (cmd_q == CMD_ADD) begin
							st_q <= SR_RD;
						end else if (n_next == '0) begin
							// empty read: one invalid beat
							out_q    <= '0;
							strobe_q <= 1'b1;
							valid_q  <= 1'b0;
							last_q   <= 1'b1;
							st_q     <= IDLE;
						end else begin
							st_q <= RD_RD;
						end
					end else begin
						st_q <= EX_EV;
					end
				end
				EX_EV: begin
					if (keep_ok) begin
						keep_q <= keep_q + 1'b1;
					end
					i_q  <= i_q + 1'b1;
					st_q <= EX_RD;
				end
				SR_RD: begin
					st_q <= (i_q == cnt_q) ? WR : SR_EV;
				end
				SR_EV: begin
					if (!hit_q && rdata.call_hi == ent_q.call_hi
							&& rdata.call_lo == ent_q.call_lo) begin
						hit_q      <= 1'b1;
						hit_idx_q  <= i_q[AW-1:0];
						hit_time_q <= rdata.time_stamp;
					end
					if (i_q == '0 || rdata.time_stamp < min_time_q) begin
						min_idx_q  <= i_q[AW-1:0];
						min_time_q <= rdata.time_stamp;
					end
					i_q  <= i_q + 1'b1;
					st_q <= SR_RD;
				end
				WR: begin
					if (!hit_q && cnt_q < CW'(TABLE_DEPTH)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					st_q <= IDLE;
				end
				RD_RD: begin
					st_q <= RD_EM;
				end
				RD_EM: begin
					out_q    <= rdata;
					strobe_q <= 1'b1;
					valid_q  <= 1'b1;
					last_q   <= (7'(i_q) + 7'd1 == n_q);
					i_q      <= i_q + 1'b1;
					st_q     <= (7'(i_q) + 7'd1 == n_q) ? IDLE : RD_RD;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign busy             = st_q != IDLE;
	assign strobe           = strobe_q;
	assign entry_valid      = valid_q;
	assign last_item        = last_q;
	assign out_call_hi      = out_q.call_hi;
	assign out_call_lo      = out_q.call_lo;
	assign out_time         = out_q.time_stamp;
	assign out_freq_hz      = out_q.freq_hz;
	assign out_snr_db       = out_q.snr_db;
	assign out_grid         = out_q.grid;
	assign out_has_position = out_q.has_position;
	assign out_lat_bits     = out_q.lat_bits;
	assign out_lon_bits     = out_q.lon_bits;

endmodule

/* design/krt_checker.sv */
// Port-level checks for the keyed report table, bound to the top level.
module krt_props (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  cmd,
	input logic        strobe,
	input logic        entry_valid,
	input logic        last_item,
	input logic [31:0] out_time
);
	import krt_pkg::*;

	// every beat comes out of a running command
	a_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("beat without command");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !entry_valid |-> last_item) else $error("empty beat not last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !entry_valid |-> out_time == '0) else $error("empty beat not zero");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_item |-> !busy) else $error("busy after last beat");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_CLEAR |=> !busy) else $error("clear held busy");

endmodule

bind keyed_report_table_ttl krt_props u_krt_props (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.strobe(strobe), .entry_valid(entry_valid), .last_item(last_item),
	.out_time(out_time)
);

/* tb/krt_checker.sv */
// Checker for the keyed report table: predicts read beats and compares them.
module krt_checker #(
	parameter int unsigned TABLE_DEPTH = krt_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ttl_we,
	input  logic [31:0]        ttl_wdata,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         cmd,
	input  logic [63:0]        call_hi,
	input  logic [55:0]        call_lo,
	input  logic [31:0]        time_stamp,
	input  logic [31:0]        freq_hz,
	input  logic signed [7:0]  snr_db,
	input  logic [47:0]        grid_text,
	input  logic               has_position,
	input  logic [31:0]        lat_bits,
	input  logic [31:0]        lon_bits,
	input  logic [5:0]         max_entries,
	input  logic               strobe,
	input  logic [63:0]        out_call_hi,
	input  logic [55:0]        out_call_lo,
	input  logic [31:0]        out_time,
	input  logic [31:0]        out_freq_hz,
	input  logic signed [7:0]  out_snr_db,
	input  logic [47:0]        out_grid,
	input  logic               out_has_position,
	input  logic [31:0]        out_lat_bits,
	input  logic [31:0]        out_lon_bits,
	input  logic               entry_valid,
	input  logic               last_item,
	output int                 errors,
	output int                 beats_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import krt_pkg::*;

	typedef struct {
		entry_t rec;
		logic   valid;
		logic   last;
	} report_beat_t;

	entry_t       reports[TABLE_DEPTH];
	int           report_count;
	logic [31:0]  ttl_limit;
	report_beat_t owed_beats[$];

	assign beats_owed = owed_beats.size();

	task automatic drop_stale(input logic [31:0] now);
		int keep;
		longint age;
		keep = 0;
		for (int i = 0; i < report_count; i++) begin
			age = longint'(now) - longint'(reports[i].time_stamp);
			if (age <= longint'(ttl_limit)) begin
				reports[keep] = reports[i];
				keep++;
			end
		end
		report_count = keep;
	endtask

	task automatic predict_command(input entry_t in_rec, input logic [1:0] op,
			input logic [5:0] limit);
		int slot;
		int n;
		report_beat_t b;
		case (op)
			CMD_ADD: begin
				drop_stale(in_rec.time_stamp);
				slot = -1;
				for (int i = 0; i < report_count; i++)
					if (slot < 0 && reports[i].call_hi == in_rec.call_hi &&
							reports[i].call_lo == in_rec.call_lo)
						slot = i;
				if (slot < 0 && report_count < TABLE_DEPTH) begin
					reports[report_count] = in_rec;
					report_count++;
				end else begin
					if (slot < 0) begin
						// full table: first entry with the smallest time
						slot = 0;
						for (int i = 1; i < TABLE_DEPTH; i++)
							if (reports[i].time_stamp < reports[slot].time_stamp)
								slot = i;
					end
					if (in_rec.time_stamp >= reports[slot].time_stamp)
						reports[slot] = in_rec;
				end
			end
			CMD_READ: begin
				drop_stale(in_rec.time_stamp);
				n = limit;
				if (n > report_count) n = report_count;
				if (n > READ_CAP) n = READ_CAP;
				if (n == 0) begin
					b.rec = '0;
					b.valid = 1'b0;
					b.last = 1'b1;
					owed_beats.push_back(b);
				end
				for (int k = 0; k < n; k++) begin
					b.rec = reports[k];
					b.valid = 1'b1;
					b.last = (k == n - 1);
					owed_beats.push_back(b);
				end
			end
			CMD_CLEAR: report_count = 0;
			default: ;
		endcase
	endtask

	task automatic compare_beat();
		report_beat_t b;
		if (owed_beats.size() == 0) begin
			$error("unexpected result beat: call_hi %h", out_call_hi);
			errors++;
			return;
		end
		b = owed_beats.pop_front();
		if (out_call_hi !== b.rec.call_hi) begin
			$error("out_call_hi exp %h got %h", b.rec.call_hi, out_call_hi); errors++;
		end
		if (out_call_lo !== b.rec.call_lo) begin
			$error("out_call_lo exp %h got %h", b.rec.call_lo, out_call_lo); errors++;
		end
		if (out_time !== b.rec.time_stamp) begin
			$error("out_time exp %h got %h", b.rec.time_stamp, out_time); errors++;
		end
		if (out_freq_hz !== b.rec.freq_hz) begin
			$error("out_freq_hz exp %h got %h", b.rec.freq_hz, out_freq_hz); errors++;
		end
		if (out_snr_db !== b.rec.snr_db) begin
			$error("out_snr_db exp %0d got %0d", b.rec.snr_db, out_snr_db); errors++;
		end
		if (out_grid !== b.rec.grid) begin
			$error("out_grid exp %h got %h", b.rec.grid, out_grid); errors++;
		end
		if (out_has_position !== b.rec.has_position) begin
			$error("out_has_position exp %b got %b", b.rec.has_position, out_has_position);
			errors++;
		end
		if (out_lat_bits !== b.rec.lat_bits) begin
			$error("out_lat_bits exp %h got %h", b.rec.lat_bits, out_lat_bits); errors++;
		end
		if (out_lon_bits !== b.rec.lon_bits) begin
			$error("out_lon_bits exp %h got %h", b.rec.lon_bits, out_lon_bits); errors++;
		end
		if (entry_valid !== b.valid) begin
			$error("entry_valid exp %b got %b", b.valid, entry_valid); errors++;
		end
		if (last_item !== b.last) begin
			$error("last_item exp %b got %b", b.last, last_item); errors++;
		end
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		entry_t in_rec;
		if (!arst_n) begin
			report_count = 0;
			ttl_limit = TTL_RESET;
			owed_beats.delete();
		end else begin
			if (strobe === 1'b1) compare_beat();
			if (ttl_we) ttl_limit = ttl_wdata;
			if (start && !busy) begin
				in_rec.call_hi = call_hi;
				in_rec.call_lo = call_lo;
				in_rec.time_stamp = time_stamp;
				in_rec.freq_hz = freq_hz;
				in_rec.snr_db = snr_db;
				in_rec.grid = grid_text;
				in_rec.has_position = has_position;
				in_rec.lat_bits = lat_bits;
				in_rec.lon_bits = lon_bits;
				predict_command(in_rec, cmd, max_entries);
			end
		end
	end

endmodule

/* tb/tb.sv */
// Testbench top: clock, reset, command stimulus, TTL phases and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import krt_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 600000;

	logic clk, arst_n, ttl_we, start, busy, strobe;
	logic [31:0] ttl_wdata;
	logic [1:0] cmd;
	logic [63:0] call_hi, out_call_hi;
	logic [55:0] call_lo, out_call_lo;
	logic [31:0] time_stamp, freq_hz, lat_bits, lon_bits;
	logic [31:0] out_time, out_freq_hz, out_lat_bits, out_lon_bits;
	logic signed [7:0] snr_db, out_snr_db;
	logic [47:0] grid_text, out_grid;
	logic has_position, out_has_position, entry_valid, last_item;
	logic [5:0] max_entries;
	int errors, beats_owed, cycles;

	logic [63:0] pool_hi[10];
	logic [55:0] pool_lo[10];
	logic [31:0] now;
	int burst_left;

	keyed_report_table_ttl dut (.*);
	krt_checker chk (.*);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		do @(negedge clk); while (busy || beats_owed != 0);
		// adds leave no beat behind, so let one full table walk finish
		repeat (200) @(negedge clk);
	endtask

	task automatic write_ttl(input logic [31:0] value);
		wait_drained();
		ttl_we = 1'b1;
		ttl_wdata = value;
		@(negedge clk);
		ttl_we = 1'b0;
	endtask

	task automatic issue(input logic [1:0] op, input logic [63:0] hi, input logic [55:0] lo,
			input logic [31:0] ts, input logic [5:0] lim);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clk);
		end
		burst_left--;
		while (busy) @(negedge clk);
		cmd = op;
		call_hi = hi;
		call_lo = lo;
		time_stamp = ts;
		freq_hz = $urandom;
		snr_db = 8'($urandom);
		grid_text = 48'({$urandom, $urandom});
		has_position = 1'($urandom);
		lat_bits = $urandom;
		lon_bits = $urandom;
		max_entries = lim;
		start = 1'b1;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic random_mix(input int count);
		int k;
		int r;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 9);
			r = $urandom_range(0, 99);
			now = now + $urandom_range(0, 20000);
			if (r < 55)
				issue(CMD_ADD, pool_hi[k], pool_lo[k],
					($urandom_range(0, 3) == 0) ? now - $urandom_range(0, 120000) : now, 0);
			else if (r < 60)
				issue(CMD_ADD, {$urandom, $urandom}, 56'({$urandom, $urandom}), $urandom, 0);
			else if (r < 88)
				issue(CMD_READ, 0, 0, ($urandom_range(0, 9) == 0) ? $urandom : now,
					6'($urandom_range(0, 63)));
			else if (r < 94)
				issue(CMD_CLEAR, 0, 0, now, 0);
			else
				issue(CMD_SPARE, pool_hi[k], pool_lo[k], now, 6'($urandom));
		end
	endtask

	task automatic fill_table(input int count);
		for (int i = 0; i < count; i++) begin
			now = now + $urandom_range(0, 50);
			issue(CMD_ADD, {$urandom, $urandom}, 56'({$urandom, $urandom}),
				now - $urandom_range(0, 500), 0);
		end
		issue(CMD_READ, 0, 0, now, 6'd63);
		issue(CMD_READ, 0, 0, now, 6'd32);
	endtask

	initial begin
		cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		ttl_we = 1'b0; ttl_wdata = '0; start = 1'b0; cmd = CMD_ADD;
		call_hi = '0; call_lo = '0; time_stamp = '0; freq_hz = '0; snr_db = '0;
		grid_text = '0; has_position = 1'b0; lat_bits = '0; lon_bits = '0;
		max_entries = '0;
		for (int i = 0; i < 10; i++) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = 56'({$urandom, $urandom});
		end
		now = 32'd1000000;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty reads, extremes, update and stale update, clear, spare op
		issue(CMD_READ, 0, 0, now, 6'd5);
		issue(CMD_ADD, '1, '1, now, 0);
		issue(CMD_ADD, '0, '0, now, 0);
		issue(CMD_READ, 0, 0, now, 6'd0);
		issue(CMD_READ, 0, 0, now, 6'd63);
		issue(CMD_ADD, pool_hi[0], pool_lo[0], now + 10, 0);
		issue(CMD_ADD, pool_hi[0], pool_lo[0], now + 20, 0);
		issue(CMD_ADD, pool_hi[0], pool_lo[0], now + 5, 0);
		issue(CMD_ADD, pool_hi[1], pool_lo[1], now + 86400 * 3, 0);
		issue(CMD_READ, 0, 0, now, 6'd1);
		issue(CMD_READ, 0, 0, now + 86400, 6'd63);
		issue(CMD_READ, 0, 0, now + 86421, 6'd63);
		issue(CMD_SPARE, pool_hi[2], pool_lo[2], now, 6'd63);
		issue(CMD_READ, 0, 0, now + 86421, 6'd63);
		issue(CMD_CLEAR, 0, 0, now, 0);
		issue(CMD_READ, 0, 0, now, 6'd63);
		issue(CMD_ADD, pool_hi[3], pool_lo[3], 32'hFFFF_FFFF, 0);
		issue(CMD_READ, 0, 0, 32'd0, 6'd63);
		issue(CMD_CLEAR, 0, 0, now, 0);

		fill_table(12);
		random_mix(10);

		write_ttl(32'd0);
		random_mix(5);
		write_ttl(32'hFFFF_FFFF);
		fill_table(36);
		random_mix(5);
		write_ttl($urandom_range(1000, 60000));
		random_mix(5);
		wait_drained();
		write_ttl(TTL_RESET);
		random_mix(5);

		wait_drained();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* keyed_report_table_ttl.f */
design/krt_pkg.sv
design/krt_ram.sv
design/keyed_report_table_ttl.sv
design/krt_checker.sv
tb/krt_checker.sv
tb/tb.sv
